[sv/tric_pkg.sv]
// Package: payload types, register indexes and widths for the triangle classifier.
package tric_pkg;
	localparam int CoordW = 16;
	localparam int DiffW  = CoordW + 1;
	localparam int MagW   = CoordW;
	localparam int SqW    = 2 * MagW + 1;
	localparam int SideW  = 17;
	localparam int RootW  = (SqW + 1) / 2;
	localparam int PerimW = 19;
	localparam int AreaW  = 32;
	localparam int CrossW = 2 * DiffW + 1;
	localparam int LenTolW = 16;
	localparam int SqTolW  = 24;
	localparam int CfgW    = 24;
	localparam int CfgIdxW = 1;
	localparam int SqrtSteps = RootW;

	localparam logic [CfgIdxW-1:0] REG_LEN_TOL = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_SQ_TOL  = 1'd1;

	typedef enum logic [1:0] {
		CLS_EQUILATERAL = 2'd0,
		CLS_ISOSCELES   = 2'd1,
		CLS_SCALENE     = 2'd2,
		CLS_INVALID     = 2'd3
	} side_class_t;

	typedef struct packed {
		logic signed [CoordW-1:0] point_a_x;
		logic signed [CoordW-1:0] point_a_y;
		logic signed [CoordW-1:0] point_b_x;
		logic signed [CoordW-1:0] point_b_y;
		logic signed [CoordW-1:0] point_c_x;
		logic signed [CoordW-1:0] point_c_y;
	} in_item_t;

	typedef struct packed {
		logic [SideW-1:0]  side_ab;
		logic [SideW-1:0]  side_bc;
		logic [SideW-1:0]  side_ca;
		logic              is_valid;
		logic [PerimW-1:0] perimeter;
		logic [AreaW-1:0]  area;
		logic [1:0]        side_class;
		logic              is_right;
	} out_item_t;

	// Per-lane square root working state carried along the cell chain.
	typedef struct packed {
		logic [SqW-1:0]   rem;
		logic [RootW-1:0] root;
	} sqrt_lane_t;

	// Side data that rides along the chain untouched.
	typedef struct packed {
		logic [SqW-1:0]    q_ab;
		logic [SqW-1:0]    q_bc;
		logic [SqW-1:0]    q_ca;
		logic [AreaW-1:0]  area;
		logic              valid;
	} carry_t;
endpackage

[sv/tric_sqrt_cell.sv]
// One digit cell of the square root chain: three lanes, one result bit each.
module tric_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  tric_pkg::sqrt_lane_t    lane_in [3],
	input  tric_pkg::carry_t        carry_in,
	output logic                    vld_out,
	output tric_pkg::sqrt_lane_t    lane_out [3],
	output tric_pkg::carry_t        carry_out
);
	import tric_pkg::*;

	localparam int Shift = 2 * (SqrtSteps - 1 - STEP);

	sqrt_lane_t nxt [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [SqW+1:0] trial;
			logic [SqW+1:0] top;
			trial = ({2'b0, SqW'(lane_in[i].root)} << 2 | (SqW+2)'(1)) << Shift;
			top = {2'b0, lane_in[i].rem};
			if (top >= trial) begin
				nxt[i].rem  = SqW'(top - trial);
				nxt[i].root = {lane_in[i].root[RootW-2:0], 1'b1};
			end else begin
				nxt[i].rem  = lane_in[i].rem;
				nxt[i].root = {lane_in[i].root[RootW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out  <= nxt;
			carry_out <= carry_in;
		end
	end
endmodule

[sv/tric_front.sv]
// Front stages: differences, products, squared distances and cross product.
module tric_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  tric_pkg::in_item_t   item,
	output logic                 vld_out,
	output tric_pkg::sqrt_lane_t lane_out [3],
	output tric_pkg::carry_t     carry_out
);
	import tric_pkg::*;

	logic signed [DiffW-1:0] d_s1 [6];
	logic                    vld_s1, vld_s2;
	logic [SqW-2:0]          sq_s2 [6];
	logic signed [CrossW-1:0] p1_s2, p2_s2;
	logic signed [CrossW-1:0] cr;
	logic [CrossW-1:0]       acr;
	logic [SqW-1:0]          q [3];

	function automatic logic [MagW-1:0] mag(input logic signed [DiffW-1:0] v);
		logic signed [DiffW-1:0] a;
		a = v < 0 ? -v : v;
		return a[MagW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_out <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// bx-ax, by-ay, cx-bx, cy-by, ax-cx, ay-cy
			d_s1[0] <= DiffW'(item.point_b_x) - DiffW'(item.point_a_x);
			d_s1[1] <= DiffW'(item.point_b_y) - DiffW'(item.point_a_y);
			d_s1[2] <= DiffW'(item.point_c_x) - DiffW'(item.point_b_x);
			d_s1[3] <= DiffW'(item.point_c_y) - DiffW'(item.point_b_y);
			d_s1[4] <= DiffW'(item.point_a_x) - DiffW'(item.point_c_x);
			d_s1[5] <= DiffW'(item.point_a_y) - DiffW'(item.point_c_y);
			for (int i = 0; i < 6; i++) sq_s2[i] <= (SqW-1)'(mag(d_s1[i])) * (SqW-1)'(mag(d_s1[i]));
			// cross = (bx-ax)(cy-ay) - (by-ay)(cx-ax); cy-ay = -(ay-cy)
			p1_s2 <= -(CrossW'(d_s1[0]) * CrossW'(d_s1[5]));
			p2_s2 <= -(CrossW'(d_s1[1]) * CrossW'(d_s1[4]));
		end
	end

	always_comb begin
		cr  = p1_s2 - p2_s2;
		acr = cr < 0 ? CrossW'(-cr) : CrossW'(cr);
		for (int i = 0; i < 3; i++) q[i] = SqW'(sq_s2[2*i]) + SqW'(sq_s2[2*i+1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lane_out[i].rem  <= q[i];
				lane_out[i].root <= '0;
			end
			carry_out.q_ab  <= q[0];
			carry_out.q_bc  <= q[1];
			carry_out.q_ca  <= q[2];
			carry_out.area  <= AreaW'(acr >> 1);
			carry_out.valid <= acr != '0;
		end
	end
endmodule

[sv/tric_back.sv]
// Back stage: perimeter, class and right-angle decisions, output register.
module tric_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  tric_pkg::sqrt_lane_t lane_in [3],
	input  tric_pkg::carry_t     carry_in,
	input  logic [tric_pkg::LenTolW-1:0] len_tol,
	input  logic [tric_pkg::SqTolW-1:0]  sq_tol,
	output logic                 vld_out,
	output tric_pkg::out_item_t  res
);
	import tric_pkg::*;

	logic [SideW-1:0] s [3];
	logic e1, e2, e3, rt;
	logic [SqW:0] sum [3];
	logic [SqW-1:0] third [3];
	side_class_t cls;

	function automatic logic [SqW:0] adiff(input logic [SqW:0] p, input logic [SqW:0] q);
		return p > q ? p - q : q - p;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) s[i] = SideW'(lane_in[i].root);
		e1 = adiff((SqW+1)'(s[0]), (SqW+1)'(s[1])) < (SqW+1)'(len_tol);
		e2 = adiff((SqW+1)'(s[1]), (SqW+1)'(s[2])) < (SqW+1)'(len_tol);
		e3 = adiff((SqW+1)'(s[2]), (SqW+1)'(s[0])) < (SqW+1)'(len_tol);
		sum[0] = (SqW+1)'(carry_in.q_ab) + (SqW+1)'(carry_in.q_bc); third[0] = carry_in.q_ca;
		sum[1] = (SqW+1)'(carry_in.q_ab) + (SqW+1)'(carry_in.q_ca); third[1] = carry_in.q_bc;
		sum[2] = (SqW+1)'(carry_in.q_bc) + (SqW+1)'(carry_in.q_ca); third[2] = carry_in.q_ab;
		rt = 1'b0;
		for (int i = 0; i < 3; i++)
			if (adiff(sum[i], (SqW+1)'(third[i])) < (SqW+1)'(sq_tol)) rt = 1'b1;
		priority if (e1 && e2) cls = CLS_EQUILATERAL;
		else if (e1 || e2 || e3) cls = CLS_ISOSCELES;
		else cls = CLS_SCALENE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.side_ab  <= s[0];
			res.side_bc  <= s[1];
			res.side_ca  <= s[2];
			res.is_valid <= carry_in.valid;
			res.perimeter <= carry_in.valid ?
				PerimW'(s[0]) + PerimW'(s[1]) + PerimW'(s[2]) : '0;
			res.area       <= carry_in.valid ? carry_in.area : '0;
			res.side_class <= carry_in.valid ? cls : CLS_INVALID;
			res.is_right   <= carry_in.valid & rt;
		end
	end
endmodule

[sv/triangle_classifier_top.sv]
// Top level: triangle classifier pipeline with a chain of square root cells.
// Pipeline: 3 front stages, 17 square root cells and 1 decision stage
//   between input beat and output beat, all advancing with the output side ready.
// Throughput: one beat per cycle; the whole pipe advances when the output
//   register is empty or being taken, so in_ready = !out_valid | out_ready.
// Reset: arst_n clears all valid bits; tolerances return to 1 and 66.
// Data registers are not reset.
module triangle_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tric_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tric_pkg::out_item_t           out_data,
	input  logic                          cfg_we,
	input  logic [tric_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tric_pkg::CfgW-1:0]     cfg_data
);
	import tric_pkg::*;

	logic en;
	logic [LenTolW-1:0] len_tol_q;
	logic [SqTolW-1:0]  sq_tol_q;

	// chain taps: index 0 is front output, SqrtSteps is last cell output
	logic       vld_c   [SqrtSteps+1];
	sqrt_lane_t lane_c  [SqrtSteps+1][3];
	carry_t     carry_c [SqrtSteps+1];

	// Pipe stalls as one: move when the output register can take a beat.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_tol_q <= LenTolW'(1);
			sq_tol_q  <= SqTolW'(66);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEN_TOL: len_tol_q <= cfg_data[LenTolW-1:0];
				REG_SQ_TOL:  sq_tol_q  <= cfg_data[SqTolW-1:0];
				default: ;
			endcase
		end
	end

	tric_front u_front (
		.clk, .arst_n, .en,
		.vld_in   (in_valid),
		.item     (in_data),
		.vld_out  (vld_c[0]),
		.lane_out (lane_c[0]),
		.carry_out(carry_c[0])
	);

	// One result bit per cell, most significant first.
	for (genvar g = 0; g < SqrtSteps; g++) begin : g_cell
		tric_sqrt_cell #(.STEP(g)) u_cell (
			.clk, .arst_n, .en,
			.vld_in   (vld_c[g]),
			.lane_in  (lane_c[g]),
			.carry_in (carry_c[g]),
			.vld_out  (vld_c[g+1]),
			.lane_out (lane_c[g+1]),
			.carry_out(carry_c[g+1])
		);
	end

	tric_back u_back (
		.clk, .arst_n, .en,
		.vld_in  (vld_c[SqrtSteps]),
		.lane_in (lane_c[SqrtSteps]),
		.carry_in(carry_c[SqrtSteps]),
		.len_tol (len_tol_q),
		.sq_tol  (sq_tol_q),
		.vld_out (out_valid),
		.res     (out_data)
	);

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready low with empty output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_valid |-> out_data.area == '0 &&
		out_data.perimeter == '0 && !out_data.is_right)
		else $error("invalid triangle with nonzero fields");
endmodule
